>>> rtl/carith_pkg.sv
// ----------------------------------------------------------------------------
// carith_pkg
// shared widths, operation codes, the pipeline word and arithmetic helpers
// ----------------------------------------------------------------------------
package carith_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int DATA_W       = 32;
    localparam int TOL_W        = 17;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int SUM_W        = PROD_W + 1;
    localparam int QUO_W        = DATA_W + 1;
    localparam int DIV_STEPS    = QUO_W;
    localparam int NUM_W        = PROD_W + FRAC_BITS;
    localparam int CMP_W        = PROD_W + DIV_STEPS;
    localparam int CX_W         = DATA_W + 3;
    localparam int CZ_W         = DATA_W + 2;
    localparam int ANG_FRAC     = 30;
    localparam int N_CELLS      = (DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS;
    localparam int IDX_W        = $clog2(N_CELLS);

    localparam logic [TOL_W-1:0]        TOL_RESET = TOL_W'(66);
    localparam logic signed [CZ_W-1:0]  HALF_PI   = CZ_W'(64'sd1686629713);
    localparam logic [ANG_FRAC-1:0]     INV_GAIN  = ANG_FRAC'(64'd652032874);
    localparam logic [DATA_W-1:0]       S_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0]       S_MIN     = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [PROD_W-1:0]       MAG_NEG_MAX = PROD_W'(1) << (DATA_W - 1);
    localparam logic [PROD_W-1:0]       MAG_POS_MAX = MAG_NEG_MAX - PROD_W'(1);

    typedef enum logic [3:0] {
        FN_ADD     = 4'd0,
        FN_SUB     = 4'd1,
        FN_MUL     = 4'd2,
        FN_DIV     = 4'd3,
        FN_CONJ    = 4'd4,
        FN_MODSQ   = 4'd5,
        FN_MODULUS = 4'd6,
        FN_PHASE   = 4'd7,
        FN_ROUND   = 4'd8,
        FN_EQUAL   = 4'd9
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    // word handed from cell to cell
    typedef struct packed {
        func_t                     func;
        logic [PROD_W-1:0]         den;
        logic                      divz;
        logic                      neg_re;
        logic                      neg_im;
        logic                      ovf_re;
        logic                      ovf_im;
        logic [NUM_W-1:0]          rem_re;
        logic [NUM_W-1:0]          rem_im;
        logic [QUO_W-1:0]          q_re;
        logic [QUO_W-1:0]          q_im;
        logic [DATA_W-1:0]         res_re;
        logic [DATA_W-1:0]         res_im;
        logic                      eq;
        logic                      sat;
        logic signed [CX_W-1:0]    cx;
        logic signed [CX_W-1:0]    cy;
        logic signed [CZ_W-1:0]    cz;
        logic                      czero;
    } cell_word_t;

    // arctan(2^-i) in Q30
    function automatic logic signed [CZ_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
        logic [31:0] a;
        case (int'(i))
            0:  a = 32'h3243F6A8;
            1:  a = 32'h1DAC6705;
            2:  a = 32'h0FADBAFC;
            3:  a = 32'h07F56EA6;
            4:  a = 32'h03FEAB76;
            5:  a = 32'h01FFD55B;
            6:  a = 32'h00FFFAAA;
            7:  a = 32'h007FFF55;
            8:  a = 32'h003FFFEA;
            9:  a = 32'h001FFFFD;
            10: a = 32'h000FFFFF;
            11: a = 32'h0007FFFF;
            12: a = 32'h0003FFFF;
            13: a = 32'h0001FFFF;
            14: a = 32'h0000FFFF;
            15: a = 32'h00007FFF;
            16: a = 32'h00003FFF;
            17: a = 32'h00001FFF;
            18: a = 32'h00000FFF;
            19: a = 32'h000007FF;
            20: a = 32'h000003FF;
            21: a = 32'h000001FF;
            22: a = 32'h000000FF;
            23: a = 32'h0000007F;
            24: a = 32'h0000003F;
            25: a = 32'h0000001F;
            26: a = 32'h0000000F;
            27: a = 32'h00000007;
            28: a = 32'h00000003;
            29: a = 32'h00000001;
            default: a = 32'h0;
        endcase
        return signed'(CZ_W'(a));
    endfunction

    // wide signed value out of the 32-bit range
    function automatic logic wide_ovf(input logic [CX_W-1:0] v);
        return !((&v[CX_W-1:DATA_W-1]) || !(|v[CX_W-1:DATA_W-1]));
    endfunction

    function automatic logic [DATA_W-1:0] wide_sat(input logic [CX_W-1:0] v);
        if (wide_ovf(v))
            return v[CX_W-1] ? S_MIN : S_MAX;
        return v[DATA_W-1:0];
    endfunction

    // sign and magnitude to 32-bit signed
    function automatic logic mag_ovf(input logic neg, input logic [PROD_W-1:0] mag);
        return neg ? (mag > MAG_NEG_MAX) : (mag > MAG_POS_MAX);
    endfunction

    function automatic logic [DATA_W-1:0] mag_val(input logic neg,
                                                  input logic [PROD_W-1:0] mag);
        if (mag_ovf(neg, mag))
            return neg ? S_MIN : S_MAX;
        return neg ? DATA_W'(-mag) : DATA_W'(mag);
    endfunction

    // snap one component to an integer when inside the tolerance
    function automatic logic [CX_W-1:0] snap_raw(input logic [DATA_W-1:0] v,
                                                 input logic [TOL_W-1:0] tol);
        logic [DATA_W-1:0] f;
        logic [DATA_W-1:0] fl;
        logic [DATA_W-1:0] one_minus;
        logic [CX_W-1:0]   fl_w;
        f         = DATA_W'(v[FRAC_BITS-1:0]);
        fl        = v - f;
        one_minus = (DATA_W'(1) << FRAC_BITS) - f;
        fl_w      = CX_W'(signed'(fl));
        if (f < DATA_W'(tol))
            return fl_w;
        if (f != '0 && one_minus < DATA_W'(tol))
            return fl_w + (CX_W'(1) << FRAC_BITS);
        return CX_W'(signed'(v));
    endfunction

endpackage

>>> rtl/carith_ifs.sv
// ----------------------------------------------------------------------------
// carith channel interfaces
// request, response and tolerance write channels, valid/ready
// ----------------------------------------------------------------------------
interface carith_req_if import carith_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic [3:0]               func;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;

    modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

interface carith_rsp_if import carith_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic                     is_equal;
    logic [1:0]               status;

    modport source (output valid, res_re, res_im, is_equal, status, input ready);
    modport sink   (input valid, res_re, res_im, is_equal, status, output ready);
endinterface

interface carith_cfg_if import carith_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] round_tolerance;

    modport source (output valid, round_tolerance, input ready);
    modport sink   (input valid, round_tolerance, output ready);
endinterface

>>> rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// complex add, sub, mul, div, conj, squared modulus, modulus, phase, round, equal
// ----------------------------------------------------------------------------
// One request word (operation code and two complex Q16.16 operands) gives one
// response word. A new request is taken every cycle while the response side
// is ready. The path holds three front stages (products, sums and simple
// operations, division and cordic setup), a chain of 33 cells and two
// output stages. The chain length is set by the divider, which resolves one
// quotient bit of both quotient components per cell; the cordic rotations
// for modulus and phase run in the first 16 of the same cells. Every stage
// holds its own valid bit, so bubbles close up and requests keep flowing
// while a finished response waits. The tolerance register is written through
// the cfg channel, which is always ready; write it only while no request is
// in flight.
module complex_arithmetic_unit import carith_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    carith_cfg_if.sink   cfg,
    carith_req_if.sink   req,
    carith_rsp_if.source rsp
);

    // tolerance register for round
    logic [TOL_W-1:0] tol_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg.valid)
            tol_reg <= cfg.round_tolerance;
    end

    // chain links, link 0 is the front output
    logic       cv [N_CELLS+1];
    logic       cr [N_CELLS+1];
    cell_word_t cw [N_CELLS+1];

    carith_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tol       (tol_reg),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .func      (req.func),
        .a_re      (req.a_re),
        .a_im      (req.a_im),
        .b_re      (req.b_re),
        .b_im      (req.b_im),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_word  (cw[0])
    );

    // cell k: quotient bit 32-k and, for k below 16, cordic rotation k
    for (genvar k = 0; k < N_CELLS; k++)
    begin : g_cell
        carith_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (IDX_W'(k)),
            .in_valid  (cv[k]),
            .in_ready  (cr[k]),
            .in_word   (cw[k]),
            .out_valid (cv[k+1]),
            .out_ready (cr[k+1]),
            .out_word  (cw[k+1])
        );
    end

    status_t st;

    carith_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cv[N_CELLS]),
        .in_ready  (cr[N_CELLS]),
        .in_word   (cw[N_CELLS]),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .res_re    (rsp.res_re),
        .res_im    (rsp.res_im),
        .is_equal  (rsp.is_equal),
        .status    (st)
    );

    assign rsp.status = st;

endmodule

>>> rtl/carith_front.sv
// ----------------------------------------------------------------------------
// carith_front
// products, simple operations and setup of the cell chain (three stages)
// ----------------------------------------------------------------------------
module carith_front import carith_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [TOL_W-1:0]         tol,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [3:0]               func,
    input  logic signed [DATA_W-1:0] a_re,
    input  logic signed [DATA_W-1:0] a_im,
    input  logic signed [DATA_W-1:0] b_re,
    input  logic signed [DATA_W-1:0] b_im,
    output logic                     out_valid,
    input  logic                     out_ready,
    output cell_word_t               out_word
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy2, rdy3;

    // stage 1: operands and products
    func_t                     f1_reg;
    logic signed [DATA_W-1:0]  ar1_reg, ai1_reg;
    logic signed [PROD_W-1:0]  p0_reg, p1_reg, p2_reg, p3_reg;
    logic [PROD_W-1:0]         p4_reg, p5_reg;
    logic signed [DATA_W-1:0]  sq_a, sq_b;
    logic                      eq1_reg;

    // stage 2: sums, simple results, cordic start
    func_t                     f2_reg;
    logic signed [SUM_W-1:0]   sre2_reg, sim2_reg, sre2_next, sim2_next;
    logic [PROD_W-1:0]         sq2_reg, sq2_next;
    logic [DATA_W-1:0]         rre2_reg, rim2_reg, rre2_next, rim2_next;
    logic                      eq2_reg, eq2_next, sat2_reg, sat2_next;
    logic signed [CX_W-1:0]    cx2_reg, cy2_reg, cx2_next, cy2_next;
    logic signed [CZ_W-1:0]    cz2_reg, cz2_next;
    logic                      cz0_reg, cz0_next;
    logic [CX_W-1:0]           t_re, t_im;

    // stage 3
    cell_word_t                w3_reg, w3_next;
    logic [PROD_W-1:0]         mag_re, mag_im, msq;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = !v1_reg || rdy2;
    assign out_valid = v3_reg;
    assign out_word  = w3_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (in_ready) v1_reg <= in_valid;
            if (rdy2)     v2_reg <= v1_reg;
            if (rdy3)     v3_reg <= v2_reg;
        end
    end

    assign sq_a = (func_t'(func) == FN_MODSQ) ? a_re : b_re;
    assign sq_b = (func_t'(func) == FN_MODSQ) ? a_im : b_im;

    always_ff @(posedge clk) begin
        if (in_valid && in_ready)
        begin
            f1_reg  <= func_t'(func);
            ar1_reg <= a_re;
            ai1_reg <= a_im;
            eq1_reg <= (a_re == b_re) && (a_im == b_im);
            p0_reg  <= PROD_W'(a_re) * PROD_W'(b_re);
            p1_reg  <= PROD_W'(a_im) * PROD_W'(b_im);
            p2_reg  <= PROD_W'(a_re) * PROD_W'(b_im);
            p3_reg  <= PROD_W'(a_im) * PROD_W'(b_re);
            p4_reg  <= PROD_W'(PROD_W'(sq_a) * PROD_W'(sq_a));
            p5_reg  <= PROD_W'(PROD_W'(sq_b) * PROD_W'(sq_b));
        end
    end

    always_comb begin
        if (f1_reg == FN_DIV)
        begin
            sre2_next = SUM_W'(p0_reg) + SUM_W'(p1_reg);
            sim2_next = SUM_W'(p3_reg) - SUM_W'(p2_reg);
        end
        else
        begin
            sre2_next = SUM_W'(p0_reg) - SUM_W'(p1_reg);
            sim2_next = SUM_W'(p2_reg) + SUM_W'(p3_reg);
        end
        sq2_next = p4_reg + p5_reg;

        t_re      = '0;
        t_im      = '0;
        eq2_next  = 1'b0;
        case (f1_reg)
            FN_ADD:
            begin
                t_re = CX_W'(ar1_reg);
                t_im = CX_W'(ai1_reg);
            end
            FN_CONJ:
            begin
                t_re = CX_W'(ar1_reg);
                t_im = -CX_W'(ai1_reg);
            end
            FN_ROUND:
            begin
                t_re = snap_raw(ar1_reg, tol);
                t_im = snap_raw(ai1_reg, tol);
            end
            FN_EQUAL: eq2_next = eq1_reg;
            default:  ;
        endcase
        rre2_next = wide_sat(t_re);
        rim2_next = wide_sat(t_im);
        sat2_next = wide_ovf(t_re) || wide_ovf(t_im);

        // start vector in the right half plane
        cz0_next = (ar1_reg == '0) && (ai1_reg == '0);
        if (ar1_reg[DATA_W-1])
        begin
            if (!ai1_reg[DATA_W-1])
            begin
                cx2_next = CX_W'(ai1_reg);
                cy2_next = -CX_W'(ar1_reg);
                cz2_next = HALF_PI;
            end
            else
            begin
                cx2_next = -CX_W'(ai1_reg);
                cy2_next = CX_W'(ar1_reg);
                cz2_next = -HALF_PI;
            end
        end
        else
        begin
            cx2_next = CX_W'(ar1_reg);
            cy2_next = CX_W'(ai1_reg);
            cz2_next = '0;
        end
    end

    // add and sub need the b operand, kept apart from the sums
    logic signed [DATA_W-1:0] br1_reg, bi1_reg;
    logic [CX_W-1:0]          as_re, as_im;

    always_ff @(posedge clk) begin
        if (in_valid && in_ready)
        begin
            br1_reg <= b_re;
            bi1_reg <= b_im;
        end
    end

    always_comb begin
        if (f1_reg == FN_SUB)
        begin
            as_re = CX_W'(ar1_reg) - CX_W'(br1_reg);
            as_im = CX_W'(ai1_reg) - CX_W'(bi1_reg);
        end
        else
        begin
            as_re = CX_W'(ar1_reg) + CX_W'(br1_reg);
            as_im = CX_W'(ai1_reg) + CX_W'(bi1_reg);
        end
    end

    always_ff @(posedge clk) begin
        if (rdy2 && v1_reg)
        begin
            f2_reg   <= f1_reg;
            sre2_reg <= sre2_next;
            sim2_reg <= sim2_next;
            sq2_reg  <= sq2_next;
            eq2_reg  <= eq2_next;
            cx2_reg  <= cx2_next;
            cy2_reg  <= cy2_next;
            cz2_reg  <= cz2_next;
            cz0_reg  <= cz0_next;
            if (f1_reg == FN_ADD || f1_reg == FN_SUB)
            begin
                rre2_reg <= wide_sat(as_re);
                rim2_reg <= wide_sat(as_im);
                sat2_reg <= wide_ovf(as_re) || wide_ovf(as_im);
            end
            else
            begin
                rre2_reg <= rre2_next;
                rim2_reg <= rim2_next;
                sat2_reg <= sat2_next;
            end
        end
    end

    always_comb begin
        mag_re = sre2_reg[SUM_W-1] ? PROD_W'(-sre2_reg) : PROD_W'(sre2_reg);
        mag_im = sim2_reg[SUM_W-1] ? PROD_W'(-sim2_reg) : PROD_W'(sim2_reg);
        msq    = sq2_reg >> FRAC_BITS;

        w3_next        = '0;
        w3_next.func   = f2_reg;
        w3_next.den    = sq2_reg;
        w3_next.divz   = (sq2_reg == '0);
        w3_next.neg_re = sre2_reg[SUM_W-1];
        w3_next.neg_im = sim2_reg[SUM_W-1];
        w3_next.ovf_re = CMP_W'(mag_re) >= (CMP_W'(sq2_reg) << (DIV_STEPS - FRAC_BITS));
        w3_next.ovf_im = CMP_W'(mag_im) >= (CMP_W'(sq2_reg) << (DIV_STEPS - FRAC_BITS));
        w3_next.rem_re = NUM_W'(mag_re) << FRAC_BITS;
        w3_next.rem_im = NUM_W'(mag_im) << FRAC_BITS;
        w3_next.eq     = eq2_reg;
        w3_next.cx     = cx2_reg;
        w3_next.cy     = cy2_reg;
        w3_next.cz     = cz2_reg;
        w3_next.czero  = cz0_reg;
        case (f2_reg)
            FN_MUL:
            begin
                w3_next.res_re = mag_val(sre2_reg[SUM_W-1], mag_re >> FRAC_BITS);
                w3_next.res_im = mag_val(sim2_reg[SUM_W-1], mag_im >> FRAC_BITS);
                w3_next.sat    = mag_ovf(sre2_reg[SUM_W-1], mag_re >> FRAC_BITS)
                              || mag_ovf(sim2_reg[SUM_W-1], mag_im >> FRAC_BITS);
            end
            FN_MODSQ:
            begin
                w3_next.res_re = mag_val(1'b0, msq);
                w3_next.sat    = mag_ovf(1'b0, msq);
            end
            default:
            begin
                w3_next.res_re = rre2_reg;
                w3_next.res_im = rim2_reg;
                w3_next.sat    = sat2_reg;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (rdy3 && v2_reg)
            w3_reg <= w3_next;
    end

endmodule

>>> rtl/carith_cell.sv
// ----------------------------------------------------------------------------
// carith_cell
// one chain cell: one quotient bit of both divisions and, in the first 16 cells, one cordic rotation
// ----------------------------------------------------------------------------
module carith_cell import carith_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  logic             in_valid,
    output logic             in_ready,
    input  cell_word_t       in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output cell_word_t       out_word
);

    logic                   valid_reg;
    cell_word_t             word_reg, word_next;
    logic [IDX_W-1:0]       bitpos;
    logic [CMP_W-1:0]       dsh, rre, rim;
    logic [QUO_W-1:0]       qbit;
    logic signed [CX_W-1:0] x, y, dx, dy;
    logic signed [CZ_W-1:0] z, ang;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb begin
        word_next = in_word;

        // restoring division step, quotient bit weight from the cell position
        bitpos = IDX_W'(DIV_STEPS - 1) - idx;
        dsh    = CMP_W'(in_word.den) << bitpos;
        qbit   = QUO_W'(1) << bitpos;
        rre    = CMP_W'(in_word.rem_re);
        rim    = CMP_W'(in_word.rem_im);
        if (idx < IDX_W'(DIV_STEPS))
        begin
            if (rre >= dsh)
            begin
                word_next.rem_re = NUM_W'(rre - dsh);
                word_next.q_re   = in_word.q_re | qbit;
            end
            if (rim >= dsh)
            begin
                word_next.rem_im = NUM_W'(rim - dsh);
                word_next.q_im   = in_word.q_im | qbit;
            end
        end

        // cordic vectoring rotation
        x   = in_word.cx;
        y   = in_word.cy;
        z   = in_word.cz;
        dx  = y >>> idx;
        dy  = x >>> idx;
        ang = atan_q30(idx);
        if (idx < IDX_W'(CORDIC_STEPS))
        begin
            if (!y[CX_W-1])
            begin
                word_next.cx = x + dx;
                word_next.cy = y - dy;
                word_next.cz = z + ang;
            end
            else
            begin
                word_next.cx = x - dx;
                word_next.cy = y + dy;
                word_next.cz = z - ang;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

endmodule

>>> rtl/carith_back.sv
// ----------------------------------------------------------------------------
// carith_back
// result formatting: quotient signs, phase rounding, modulus gain, output word
// ----------------------------------------------------------------------------
module carith_back import carith_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cell_word_t         in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DATA_W-1:0]  res_re,
    output logic [DATA_W-1:0]  res_im,
    output logic               is_equal,
    output status_t            status
);

    localparam int MOD_W = CX_W - 1 + ANG_FRAC;

    logic               va_reg, vb_reg, rdyb;
    logic [DATA_W-1:0]  rea_reg, ima_reg, rea_next, ima_next;
    logic               eqa_reg, moda_reg, moda_next;
    status_t            sta_reg, sta_next;
    logic [MOD_W-1:0]   proda_reg, proda_next;
    logic [CX_W-2:0]    xpos;
    logic [CX_W-1:0]    ph;
    logic [PROD_W-1:0]  qre, qim;
    logic               ore, oim;

    logic [DATA_W-1:0]  reb_reg, imb_reg, reb_next;
    logic               eqb_reg;
    status_t            stb_reg, stb_next;
    logic [MOD_W-ANG_FRAC-1:0] mag;

    assign rdyb     = !vb_reg || out_ready;
    assign in_ready = !va_reg || rdyb;

    always_comb begin
        xpos       = in_word.cx[CX_W-1] ? '0 : in_word.cx[CX_W-2:0];
        proda_next = MOD_W'(xpos) * MOD_W'(INV_GAIN);

        ph = (CX_W'(in_word.cz) + (CX_W'(1) << (ANG_FRAC - 1 - FRAC_BITS)))
             >>> (ANG_FRAC - FRAC_BITS);
        ph = signed'(ph);

        qre = PROD_W'(in_word.q_re);
        qim = PROD_W'(in_word.q_im);
        ore = in_word.ovf_re || mag_ovf(in_word.neg_re, qre);
        oim = in_word.ovf_im || mag_ovf(in_word.neg_im, qim);

        rea_next  = '0;
        ima_next  = '0;
        moda_next = 1'b0;
        sta_next  = ST_OK;
        case (in_word.func)
            FN_DIV:
            begin
                if (in_word.divz)
                    sta_next = ST_DIVZ;
                else
                begin
                    rea_next = in_word.ovf_re ? (in_word.neg_re ? S_MIN : S_MAX)
                                              : mag_val(in_word.neg_re, qre);
                    ima_next = in_word.ovf_im ? (in_word.neg_im ? S_MIN : S_MAX)
                                              : mag_val(in_word.neg_im, qim);
                    sta_next = (ore || oim) ? ST_SAT : ST_OK;
                end
            end
            FN_MODULUS: moda_next = !in_word.czero;
            FN_PHASE:
            begin
                if (!in_word.czero)
                begin
                    rea_next = wide_sat(ph);
                    sta_next = wide_ovf(ph) ? ST_SAT : ST_OK;
                end
            end
            default:
            begin
                rea_next = in_word.res_re;
                ima_next = in_word.res_im;
                sta_next = in_word.sat ? ST_SAT : ST_OK;
            end
        endcase
    end

    always_comb begin
        mag = proda_reg[MOD_W-1:ANG_FRAC];
        if (moda_reg)
        begin
            reb_next = mag_val(1'b0, PROD_W'(mag));
            stb_next = mag_ovf(1'b0, PROD_W'(mag)) ? ST_SAT : ST_OK;
        end
        else
        begin
            reb_next = rea_reg;
            stb_next = sta_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (in_ready) va_reg <= in_valid;
            if (rdyb)     vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid)
        begin
            rea_reg   <= rea_next;
            ima_reg   <= ima_next;
            eqa_reg   <= in_word.eq;
            moda_reg  <= moda_next;
            sta_reg   <= sta_next;
            proda_reg <= proda_next;
        end
        if (rdyb && va_reg)
        begin
            reb_reg <= reb_next;
            imb_reg <= ima_reg;
            eqb_reg <= eqa_reg;
            stb_reg <= stb_next;
        end
    end

    assign out_valid = vb_reg;
    assign res_re    = reb_reg;
    assign res_im    = imb_reg;
    assign is_equal  = eqb_reg;
    assign status    = stb_reg;

endmodule
